### hdl/srsw_pkg.sv
`timescale 1ns / 1ps

package srsw_pkg;

    localparam int WINDOW      = 8;
    localparam int IDX_W       = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int MAX_PAYLOAD = 512;

    localparam int CMD_W  = 2;
    localparam int SEQ_W  = 16;
    localparam int LEN_W  = 10;
    localparam int KIND_W = 3;
    localparam int MOD_W  = 17;
    localparam int TMR_W  = 16;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(2);
    localparam logic [MOD_W-1:0] MOD_MAX   = MOD_W'(65536);
    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(25601);
    localparam logic [TMR_W-1:0] TMR_RESET = TMR_W'(500);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_OFFER = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SENT     = 3'd0,
        KIND_REFUSED  = 3'd1,
        KIND_RETRANS  = 3'd2,
        KIND_ACKED    = 3'd3,
        KIND_IGNORED  = 3'd4,
        KIND_STEP_END = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        REG_MODULUS = 2'd0,
        REG_TIMEOUT = 2'd1,
        REG_START   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic             start;
        logic [MOD_W-1:0] dividend;
        logic [MOD_W-1:0] divisor;
    } srsw_mod_req_t;

    typedef struct packed {
        logic             done;
        logic [SEQ_W-1:0] remainder;
    } srsw_mod_rsp_t;

    // Ring successor of a slot index.
    function automatic logic [IDX_W-1:0] srsw_inc_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(WINDOW - 1))
            res = '0;
        else
            res = idx + IDX_W'(1);
        return res;
    endfunction

endpackage

### hdl/srsw_ifs.sv
`timescale 1ns / 1ps

interface srsw_item_if import srsw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [SEQ_W-1:0] ack_number;
    logic [LEN_W-1:0] seg_length;

    modport source (output valid, command, ack_number, seg_length, input ready);
    modport sink   (input valid, command, ack_number, seg_length, output ready);
endinterface

interface srsw_result_if import srsw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq_number;
    logic [LEN_W-1:0]  out_length;
    logic [IDX_W-1:0]  slot;
    logic [CNT_W-1:0]  in_flight;
    logic              all_done;
    logic              last;

    modport source (output valid, kind, seq_number, out_length, slot, in_flight, all_done,
                    last, input ready);
    modport sink   (input valid, kind, seq_number, out_length, slot, in_flight, all_done,
                    last, output ready);
endinterface

### hdl/srsw_mod.sv
`timescale 1ns / 1ps

module srsw_mod import srsw_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  srsw_mod_req_t req,
    output srsw_mod_rsp_t rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam int STEP_W = $clog2(MOD_W + 1);

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [MOD_W-1:0]    dvd_reg;
    logic [MOD_W-1:0]    acc_reg;
    logic [MOD_W-1:0]    dsr_reg;
    logic                done_reg;

    logic [MOD_W:0]      trial;
    logic                fits;
    logic [MOD_W-1:0]    acc_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial    = {acc_reg, dvd_reg[MOD_W-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        acc_next = fits ? MOD_W'(trial - {1'b0, dsr_reg}) : trial[MOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        dsr_reg <= req.divisor;
                        if (req.dividend < req.divisor)
                        begin
                            acc_reg  <= req.dividend;
                            done_reg <= 1'b1;
                        end
                        else if ({1'b0, req.dividend} < {req.divisor, 1'b0})
                        begin
                            acc_reg  <= req.dividend - req.divisor;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            acc_reg   <= '0;
                            dvd_reg   <= req.dividend;
                            step_reg  <= STEP_W'(MOD_W);
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    acc_reg  <= acc_next;
                    dvd_reg  <= {dvd_reg[MOD_W-2:0], 1'b0};
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == STEP_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = acc_reg[SEQ_W-1:0];

endmodule

### hdl/selective_repeat_sender_window.sv
`timescale 1ns / 1ps
// Per item: a tick walks the occupied slots from base; an ACK searches the slots in index order
// and, on a match, frees acked slots from base; an offer is ignored after end of data, marks end
// of data with a zero length, is refused or is sent. Every item ends with a step end beat. The
// shared remainder unit answers directly when the dividend is below twice the modulus, else it runs its restoring loop.
// Throughput: one item at a time; item ready drops from accept until the step end beat is loaded.
// Reset (rst_n, async, active low): window empty, config at defaults, next seq = 0.
module selective_repeat_sender_window import srsw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    srsw_item_if.sink             item,
    srsw_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_SCAN,
        ST_A_PICK,
        ST_A_WAIT,
        ST_A_SLIDE,
        ST_A_EMIT,
        ST_A_MISS,
        ST_O_MOD1,
        ST_O_DECIDE,
        ST_O_MOD2,
        ST_O_EMIT,
        ST_END
    } state_t;

    // Configuration registers
    logic [MOD_W-1:0] seq_modulus_reg;
    logic [TMR_W-1:0] timeout_ticks_reg;
    logic [SEQ_W-1:0] start_seq_reg;

    // Window slots: payload arrays without reset, valid/acked flags reset
    logic [SEQ_W-1:0] slot_seq_reg   [WINDOW];
    logic [LEN_W-1:0] slot_len_reg   [WINDOW];
    logic [TMR_W-1:0] slot_timer_reg [WINDOW];
    logic [WINDOW-1:0] slot_valid_reg;
    logic [WINDOW-1:0] slot_acked_reg;

    logic [IDX_W-1:0] base_index_reg;
    logic [IDX_W-1:0] next_index_reg;
    logic [CNT_W-1:0] occupied_reg;
    logic [SEQ_W-1:0] next_seq_reg;
    logic             end_seen_reg;

    // Sequencer
    state_t           state_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [CNT_W-1:0] walk_reg;
    logic [SEQ_W-1:0] ack_reg;
    logic [LEN_W-1:0] len_reg;
    logic [SEQ_W-1:0] seq_reg;

    // Shared remainder unit request
    logic             mod_start_reg;
    logic [MOD_W-1:0] mod_dividend_reg;
    srsw_mod_req_t    mod_req;
    srsw_mod_rsp_t    mod_rsp;

    // Result register
    logic              res_valid_reg;
    logic [KIND_W-1:0] res_kind_reg;
    logic [SEQ_W-1:0]  res_seq_reg;
    logic [LEN_W-1:0]  res_len_reg;
    logic [IDX_W-1:0]  res_slot_reg;
    logic [CNT_W-1:0]  res_flight_reg;
    logic              res_done_reg;
    logic              res_last_reg;

    logic [MOD_W-1:0] eff_modulus;
    logic [TMR_W-1:0] eff_timeout;
    logic             out_free;
    logic             cfg_write;
    logic [LEN_W-1:0] len_sat;
    logic             all_done_now;
    logic [SEQ_W-1:0] ptr_seq;
    logic [LEN_W-1:0] ptr_len;
    logic [TMR_W-1:0] ptr_timer;

    // Clamp the modulus into 2..65536; a zero timeout acts as one tick.
    always_comb
    begin
        if (seq_modulus_reg < MOD_MIN)
            eff_modulus = MOD_MIN;
        else if (seq_modulus_reg > MOD_MAX)
            eff_modulus = MOD_MAX;
        else
            eff_modulus = seq_modulus_reg;
        eff_timeout = (timeout_ticks_reg == '0) ? TMR_W'(1) : timeout_ticks_reg;
    end

    assign out_free     = !res_valid_reg || result.ready;
    assign cfg_write    = psel && penable && pwrite;
    assign len_sat      = (item.seg_length > LEN_MAX) ? LEN_MAX : item.seg_length;
    assign all_done_now = end_seen_reg && (occupied_reg == '0);

    // Single read port on the slot arrays, steered by the sequencer pointer
    assign ptr_seq   = slot_seq_reg[ptr_reg];
    assign ptr_len   = slot_len_reg[ptr_reg];
    assign ptr_timer = slot_timer_reg[ptr_reg];

    assign mod_req.start    = mod_start_reg;
    assign mod_req.dividend = mod_dividend_reg;
    assign mod_req.divisor  = eff_modulus;

    srsw_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            seq_modulus_reg   <= MOD_RESET;
            timeout_ticks_reg <= TMR_RESET;
            start_seq_reg     <= '0;
            slot_valid_reg    <= '0;
            slot_acked_reg    <= '0;
            base_index_reg    <= '0;
            next_index_reg    <= '0;
            occupied_reg      <= '0;
            next_seq_reg      <= '0;
            end_seen_reg      <= 1'b0;
            mod_start_reg     <= 1'b0;
            res_valid_reg     <= 1'b0;
            ptr_reg           <= '0;
            walk_reg          <= '0;
        end
        else
        begin
            mod_start_reg <= 1'b0;
            // Drop the result beat once the sink takes it; an emit below reloads it.
            if (res_valid_reg && result.ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item.valid)
                    begin
                        ack_reg <= item.ack_number;
                        len_reg <= len_sat;
                        unique case (item.command)
                            CMD_TICK:
                            begin
                                ptr_reg  <= base_index_reg;
                                walk_reg <= '0;
                                state_reg <= (occupied_reg == '0) ? ST_END : ST_T_SCAN;
                            end
                            CMD_ACK:
                            begin
                                ptr_reg   <= '0;
                                state_reg <= ST_A_PICK;
                            end
                            CMD_OFFER:
                            begin
                                if (item.seg_length == '0)
                                begin
                                    end_seen_reg <= 1'b1;
                                    state_reg    <= ST_END;
                                end
                                else if (end_seen_reg)
                                begin
                                    state_reg <= ST_END;
                                end
                                else
                                begin
                                    // Reduce next seq, which may still hold a raw start value
                                    mod_start_reg    <= 1'b1;
                                    mod_dividend_reg <= {1'b0, next_seq_reg};
                                    state_reg        <= ST_O_MOD1;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_END;
                            end
                        endcase
                    end
                end

                // Walk the window from base, one slot a cycle; hold while a
                // retransmit beat cannot be placed.
                ST_T_SCAN:
                begin
                    if (slot_valid_reg[ptr_reg] && !slot_acked_reg[ptr_reg]
                        && ptr_timer <= TMR_W'(1))
                    begin
                        if (out_free)
                        begin
                            slot_timer_reg[ptr_reg] <= eff_timeout;
                            res_valid_reg  <= 1'b1;
                            res_kind_reg   <= KIND_RETRANS;
                            res_seq_reg    <= ptr_seq;
                            res_len_reg    <= ptr_len;
                            res_slot_reg   <= ptr_reg;
                            res_flight_reg <= occupied_reg;
                            res_done_reg   <= all_done_now;
                            res_last_reg   <= 1'b0;
                            ptr_reg        <= srsw_inc_idx(ptr_reg);
                            walk_reg       <= walk_reg + CNT_W'(1);
                            if (walk_reg + CNT_W'(1) == occupied_reg)
                                state_reg <= ST_END;
                        end
                    end
                    else
                    begin
                        if (slot_valid_reg[ptr_reg] && !slot_acked_reg[ptr_reg])
                            slot_timer_reg[ptr_reg] <= ptr_timer - TMR_W'(1);
                        ptr_reg  <= srsw_inc_idx(ptr_reg);
                        walk_reg <= walk_reg + CNT_W'(1);
                        if (walk_reg + CNT_W'(1) == occupied_reg)
                            state_reg <= ST_END;
                    end
                end

                // Search slots in index order for the first end-of-segment match.
                ST_A_PICK:
                begin
                    if (slot_valid_reg[ptr_reg])
                    begin
                        mod_start_reg    <= 1'b1;
                        mod_dividend_reg <= MOD_W'(ptr_seq) + MOD_W'(ptr_len);
                        state_reg        <= ST_A_WAIT;
                    end
                    else if (ptr_reg == IDX_W'(WINDOW - 1))
                    begin
                        state_reg <= ST_A_MISS;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + IDX_W'(1);
                    end
                end

                ST_A_WAIT:
                begin
                    if (mod_rsp.done)
                    begin
                        if (mod_rsp.remainder == ack_reg)
                        begin
                            slot_acked_reg[ptr_reg] <= 1'b1;
                            state_reg               <= ST_A_SLIDE;
                        end
                        else if (ptr_reg == IDX_W'(WINDOW - 1))
                        begin
                            state_reg <= ST_A_MISS;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg + IDX_W'(1);
                            state_reg <= ST_A_PICK;
                        end
                    end
                end

                // Advance base over acked slots, freeing each one.
                ST_A_SLIDE:
                begin
                    if (slot_valid_reg[base_index_reg] && slot_acked_reg[base_index_reg])
                    begin
                        slot_valid_reg[base_index_reg] <= 1'b0;
                        slot_acked_reg[base_index_reg] <= 1'b0;
                        base_index_reg <= srsw_inc_idx(base_index_reg);
                        if (occupied_reg != '0)
                            occupied_reg <= occupied_reg - CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= ST_A_EMIT;
                    end
                end

                ST_A_EMIT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_kind_reg   <= KIND_ACKED;
                        res_seq_reg    <= ptr_seq;
                        res_len_reg    <= ptr_len;
                        res_slot_reg   <= ptr_reg;
                        res_flight_reg <= occupied_reg;
                        res_done_reg   <= all_done_now;
                        res_last_reg   <= 1'b0;
                        state_reg      <= ST_END;
                    end
                end

                ST_A_MISS:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_kind_reg   <= KIND_IGNORED;
                        res_seq_reg    <= '0;
                        res_len_reg    <= '0;
                        res_slot_reg   <= '0;
                        res_flight_reg <= occupied_reg;
                        res_done_reg   <= all_done_now;
                        res_last_reg   <= 1'b0;
                        state_reg      <= ST_END;
                    end
                end

                ST_O_MOD1:
                begin
                    if (mod_rsp.done)
                    begin
                        seq_reg   <= mod_rsp.remainder;
                        state_reg <= ST_O_DECIDE;
                    end
                end

                ST_O_DECIDE:
                begin
                    if (occupied_reg >= CNT_W'(WINDOW))
                    begin
                        if (out_free)
                        begin
                            res_valid_reg  <= 1'b1;
                            res_kind_reg   <= KIND_REFUSED;
                            res_seq_reg    <= seq_reg;
                            res_len_reg    <= len_reg;
                            res_slot_reg   <= next_index_reg;
                            res_flight_reg <= occupied_reg;
                            res_done_reg   <= all_done_now;
                            res_last_reg   <= 1'b0;
                            state_reg      <= ST_END;
                        end
                    end
                    else
                    begin
                        slot_seq_reg[next_index_reg]   <= seq_reg;
                        slot_len_reg[next_index_reg]   <= len_reg;
                        slot_timer_reg[next_index_reg] <= eff_timeout;
                        slot_valid_reg[next_index_reg] <= 1'b1;
                        slot_acked_reg[next_index_reg] <= 1'b0;
                        ptr_reg          <= next_index_reg;
                        next_index_reg   <= srsw_inc_idx(next_index_reg);
                        occupied_reg     <= occupied_reg + CNT_W'(1);
                        mod_start_reg    <= 1'b1;
                        mod_dividend_reg <= MOD_W'(seq_reg) + MOD_W'(len_reg);
                        state_reg        <= ST_O_MOD2;
                    end
                end

                ST_O_MOD2:
                begin
                    if (mod_rsp.done)
                    begin
                        next_seq_reg <= mod_rsp.remainder;
                        state_reg    <= ST_O_EMIT;
                    end
                end

                ST_O_EMIT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_kind_reg   <= KIND_SENT;
                        res_seq_reg    <= seq_reg;
                        res_len_reg    <= len_reg;
                        res_slot_reg   <= ptr_reg;
                        res_flight_reg <= occupied_reg;
                        res_done_reg   <= all_done_now;
                        res_last_reg   <= 1'b0;
                        state_reg      <= ST_END;
                    end
                end

                ST_END:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_kind_reg   <= KIND_STEP_END;
                        res_seq_reg    <= '0;
                        res_len_reg    <= '0;
                        res_slot_reg   <= '0;
                        res_flight_reg <= occupied_reg;
                        res_done_reg   <= all_done_now;
                        res_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Register writes; a start write also reloads the next sequence number.
            if (cfg_write)
            begin
                unique case (paddr[3:2])
                    REG_MODULUS: seq_modulus_reg   <= pwdata[MOD_W-1:0];
                    REG_TIMEOUT: timeout_ticks_reg <= pwdata[TMR_W-1:0];
                    REG_START:
                    begin
                        start_seq_reg <= pwdata[SEQ_W-1:0];
                        next_seq_reg  <= pwdata[SEQ_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODULUS: prdata = CFG_DATA_W'(seq_modulus_reg);
            REG_TIMEOUT: prdata = CFG_DATA_W'(timeout_ticks_reg);
            REG_START:   prdata = CFG_DATA_W'(start_seq_reg);
            default:     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign item.ready = (state_reg == ST_IDLE);

    assign result.valid      = res_valid_reg;
    assign result.kind       = res_kind_reg;
    assign result.seq_number = res_seq_reg;
    assign result.out_length = res_len_reg;
    assign result.slot       = res_slot_reg;
    assign result.in_flight  = res_flight_reg;
    assign result.all_done   = res_done_reg;
    assign result.last       = res_last_reg;

endmodule

### test/srsw_window_checker.sv
`timescale 1ns / 1ps

module srsw_window_checker import srsw_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    srsw_item_if                  item,
    srsw_result_if                result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    failures,
    output int                    outstanding
);

    typedef struct packed {
        kind_t            kind;
        logic [SEQ_W-1:0] seq_number;
        logic [LEN_W-1:0] out_length;
        logic [IDX_W-1:0] slot;
        logic [CNT_W-1:0] in_flight;
        logic             all_done;
        logic             last;
    } report_t;

    report_t report_q[$];

    // Shadow configuration and window state
    logic [MOD_W-1:0]  modulus_reg;
    logic [TMR_W-1:0]  timeout_reg;
    logic [SEQ_W-1:0]  seq_cursor;
    logic [SEQ_W-1:0]  seg_seq   [WINDOW];
    logic [LEN_W-1:0]  seg_len   [WINDOW];
    logic [TMR_W-1:0]  seg_timer [WINDOW];
    logic [WINDOW-1:0] seg_live;
    logic [WINDOW-1:0] seg_acked;
    logic [IDX_W-1:0]  base_ptr;
    logic [IDX_W-1:0]  fill_ptr;
    int unsigned       occupancy;
    logic              eod_seen;

    function automatic int unsigned modulus_eff();
        if (modulus_reg < MOD_MIN)
            return 2;
        if (modulus_reg > MOD_MAX)
            return 65536;
        return modulus_reg;
    endfunction

    function automatic logic [TMR_W-1:0] timeout_eff();
        return (timeout_reg == '0) ? TMR_W'(1) : timeout_reg;
    endfunction

    function automatic string describe(report_t r);
        return $sformatf("kind=%0d seq=%0d len=%0d slot=%0d in_flight=%0d done=%0b last=%0b",
                         r.kind, r.seq_number, r.out_length, r.slot, r.in_flight,
                         r.all_done, r.last);
    endfunction

    task automatic post_report(kind_t kind, int unsigned seq, logic [LEN_W-1:0] len,
                               int unsigned slot);
        report_t r;
        r.kind       = kind;
        r.seq_number = SEQ_W'(seq);
        r.out_length = len;
        r.slot       = IDX_W'(slot);
        r.in_flight  = CNT_W'(occupancy);
        r.all_done   = eod_seen && (occupancy == 0);
        r.last       = (kind == KIND_STEP_END);
        report_q.push_back(r);
    endtask

    task automatic advance_window(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] ack,
                                  logic [LEN_W-1:0] len);
        int unsigned      m;
        int unsigned      idx;
        int unsigned      n;
        int unsigned      seq;
        int               hit;
        logic [LEN_W-1:0] seg;
        m = modulus_eff();
        case (cmd)
            CMD_TICK:
            begin
                idx = base_ptr;
                n   = occupancy;
                for (int i = 0; i < n && i < WINDOW; i++)
                begin
                    if (seg_live[idx] && !seg_acked[idx])
                    begin
                        if (seg_timer[idx] <= 1)
                        begin
                            seg_timer[idx] = timeout_eff();
                            post_report(KIND_RETRANS, seg_seq[idx], seg_len[idx], idx);
                        end
                        else
                            seg_timer[idx] = seg_timer[idx] - 1'b1;
                    end
                    idx = (idx + 1) % WINDOW;
                end
            end
            CMD_ACK:
            begin
                hit = -1;
                for (int i = 0; i < WINDOW; i++)
                begin
                    if (hit < 0 && seg_live[i]
                        && (32'(seg_seq[i]) + 32'(seg_len[i])) % m == 32'(ack))
                        hit = i;
                end
                if (hit < 0)
                    post_report(KIND_IGNORED, 0, '0, 0);
                else
                begin
                    seg_acked[hit] = 1'b1;
                    for (int i = 0; i < WINDOW; i++)
                    begin
                        if (!(seg_live[base_ptr] && seg_acked[base_ptr]))
                            break;
                        seg_live[base_ptr]  = 1'b0;
                        seg_acked[base_ptr] = 1'b0;
                        base_ptr = IDX_W'((base_ptr + 1) % WINDOW);
                        if (occupancy > 0)
                            occupancy--;
                    end
                    post_report(KIND_ACKED, seg_seq[hit], seg_len[hit], hit);
                end
            end
            CMD_OFFER:
            begin
                if (len == '0)
                    eod_seen = 1'b1;
                else if (!eod_seen)
                begin
                    seq = 32'(seq_cursor) % m;
                    seg = (len > LEN_MAX) ? LEN_MAX : len;
                    if (occupancy >= WINDOW)
                        post_report(KIND_REFUSED, seq, seg, fill_ptr);
                    else
                    begin
                        seg_seq[fill_ptr]   = SEQ_W'(seq);
                        seg_len[fill_ptr]   = seg;
                        seg_timer[fill_ptr] = timeout_eff();
                        seg_live[fill_ptr]  = 1'b1;
                        seg_acked[fill_ptr] = 1'b0;
                        idx        = fill_ptr;
                        fill_ptr   = IDX_W'((fill_ptr + 1) % WINDOW);
                        occupancy++;
                        seq_cursor = SEQ_W'((seq + seg) % m);
                        post_report(KIND_SENT, seq, seg, idx);
                    end
                end
            end
            default:
            begin
                // unknown command: step end only
            end
        endcase
        post_report(KIND_STEP_END, 0, '0, 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t seen;
        report_t want;
        if (!rst_n)
        begin
            modulus_reg = MOD_RESET;
            timeout_reg = TMR_RESET;
            seq_cursor  = '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                seg_seq[i]   = '0;
                seg_len[i]   = '0;
                seg_timer[i] = '0;
            end
            seg_live    = '0;
            seg_acked   = '0;
            base_ptr    = '0;
            fill_ptr    = '0;
            occupancy   = 0;
            eod_seen    = 1'b0;
            report_q.delete();
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_MODULUS: modulus_reg = pwdata[MOD_W-1:0];
                    REG_TIMEOUT: timeout_reg = pwdata[TMR_W-1:0];
                    REG_START:   seq_cursor  = pwdata[SEQ_W-1:0];
                    default:     ;
                endcase
            end
            if (item.valid && item.ready)
                advance_window(item.command, item.ack_number, item.seg_length);
            if (result.valid && result.ready)
            begin
                seen = '{kind: kind_t'(result.kind), seq_number: result.seq_number,
                         out_length: result.out_length, slot: result.slot,
                         in_flight: result.in_flight, all_done: result.all_done,
                         last: result.last};
                if (report_q.size() == 0)
                begin
                    $display("%0t: unexpected beat: %s", $time, describe(seen));
                    failures <= failures + 1;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (seen !== want)
                    begin
                        $display("%0t: mismatch: expected %s", $time, describe(want));
                        $display("%0t:           actual   %s", $time, describe(seen));
                        failures <= failures + 1;
                    end
                end
            end
            outstanding <= report_q.size();
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import srsw_pkg::*;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 300;
    // Command code the block does not define; it must answer with a step end only.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    failures;
    int                    outstanding;

    // Idle control: calm is shared by the sender and the receiver, hold_req is for the receiver
    logic calm;
    logic hold_req;

    // Stimulus-side view of what the block has sent, used to aim ACKs
    int unsigned       cur_mod;
    logic [SEQ_W-1:0]  sent_seq [WINDOW];
    logic [LEN_W-1:0]  sent_len [WINDOW];
    logic [WINDOW-1:0] sent_seen;
    logic [CNT_W-1:0]  window_fill;

    srsw_item_if   cmd_bus ();
    srsw_result_if report_bus ();

    selective_repeat_sender_window uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (cmd_bus),
        .result  (report_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    srsw_window_checker window_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (cmd_bus),
        .result      (report_bus),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: reaching this means the block hung or starved a channel.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // Track sent segments that still wait for their ACK, by slot, so that ACKs
    // can target them, and remember the latest occupancy the block reported.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_seen   <= '0;
            window_fill <= '0;
        end
        else if (report_bus.valid && report_bus.ready)
        begin
            window_fill <= report_bus.in_flight;
            if (kind_t'(report_bus.kind) == KIND_SENT)
            begin
                sent_seq[report_bus.slot]  <= report_bus.seq_number;
                sent_len[report_bus.slot]  <= report_bus.out_length;
                sent_seen[report_bus.slot] <= 1'b1;
            end
            else if (kind_t'(report_bus.kind) == KIND_ACKED)
            begin
                sent_seen[report_bus.slot] <= 1'b0;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
    endfunction

    // ACK number that completes the segment last sent from slot s.
    function automatic logic [SEQ_W-1:0] ack_for_slot(int s);
        return SEQ_W'((32'(sent_seq[s]) + 32'(sent_len[s])) % cur_mod);
    endfunction

    // Result receiver: random stalls, plus one long hold-off on request so that
    // the block backs up and drops item ready while the sender keeps offering.
    initial
    begin : result_sink
        logic held;
        held = 1'b0;
        report_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                report_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                report_bus.ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            report_bus.ready <= 1'b1;
        end
    end

    // Offer one beat and hold it until the block takes it. Called at a rising
    // edge; returns at the edge where the beat was accepted.
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] ack,
                             logic [LEN_W-1:0] len);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= cmd;
        cmd_bus.ack_number <= ack;
        cmd_bus.seg_length <= len;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic settle();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Setup cycle, then access cycle held until pready.
    task automatic write_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({r, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_MODULUS)
        begin
            if (v[MOD_W-1:0] < MOD_MIN)
                cur_mod = 2;
            else if (v[MOD_W-1:0] > MOD_MAX)
                cur_mod = 65536;
            else
                cur_mod = v[MOD_W-1:0];
        end
    endtask

    // One random beat: mostly offers, ACKs aimed at sent segments and ticks;
    // the rest stray ACKs and unknown commands. Unused fields carry noise.
    task automatic random_item();
        int unsigned      pick;
        int               s;
        logic [SEQ_W-1:0] noise;
        logic [LEN_W-1:0] len;
        pick  = $urandom_range(0, 99);
        s     = $urandom_range(0, WINDOW - 1);
        noise = SEQ_W'($urandom_range(0, 65535));
        len   = LEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(MAX_PAYLOAD + 1, 1023)
                                                   : $urandom_range(1, MAX_PAYLOAD));
        if (pick < 35)
            send_item(CMD_OFFER, noise, len);
        else if (pick < 65 && sent_seen[s])
            send_item(CMD_ACK, ack_for_slot(s), len);
        else if (pick < 75)
            send_item(CMD_ACK, noise, len);
        else if (pick < 95)
            send_item(CMD_TICK, noise, len);
        else
            send_item(CMD_UNKNOWN, noise, len);
    endtask

    // ACK every slot still waiting, for up to four rounds or until the window reads empty.
    task automatic drain_window();
        for (int round = 0; round < 4 && window_fill != 0; round++)
        begin
            for (int s = 0; s < WINDOW; s++)
            begin
                if (sent_seen[s])
                    send_item(CMD_ACK, ack_for_slot(s), LEN_W'($urandom_range(0, 1023)));
            end
            settle();
        end
    endtask

    // Empty the window under the old settings, then reconfigure while idle
    // and run a batch of random beats.
    task automatic run_phase(logic [CFG_DATA_W-1:0] modulus, logic [CFG_DATA_W-1:0] ticks,
                             logic [CFG_DATA_W-1:0] start, int count);
        drain_window();
        settle();
        write_reg(REG_MODULUS, modulus);
        write_reg(REG_TIMEOUT, ticks);
        write_reg(REG_START, start);
        repeat (count) random_item();
    endtask

    initial
    begin : stimulus
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.command    <= CMD_TICK;
        cmd_bus.ack_number <= '0;
        cmd_bus.seg_length <= '0;
        calm               <= 1'b1;
        hold_req           <= 1'b0;
        cur_mod             = MOD_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset configuration, no idling. Lengths 1, 512, 1023 and
        // 700 (both overlong, saturated) land at seq 0, 1, 513, 1025.
        send_item(CMD_OFFER, 16'hFFFF, 10'd1);
        send_item(CMD_OFFER, 16'h0000, 10'd512);
        send_item(CMD_OFFER, 16'hFFFF, 10'd1023);
        send_item(CMD_OFFER, 16'h0000, 10'd700);
        send_item(CMD_TICK, 16'hFFFF, 10'd1023);
        // Ack the base segment, then the same number again once its slot is freed.
        send_item(CMD_ACK, 16'd1, 10'd0);
        send_item(CMD_ACK, 16'd1, 10'd1023);
        send_item(CMD_ACK, 16'hFFFF, 10'd0);
        // Out-of-order ACK leaves the base in place; repeating it still matches.
        send_item(CMD_ACK, 16'd1025, 10'd0);
        send_item(CMD_ACK, 16'd1025, 10'd0);
        send_item(CMD_UNKNOWN, 16'hFFFF, 10'd1023);
        // Fill the window, then one more offer is refused.
        repeat (5) send_item(CMD_OFFER, 16'd0, 10'd300);
        send_item(CMD_OFFER, 16'd0, 10'd20);
        // Ack the base: the window slides over it and the earlier out-of-order ACK.
        send_item(CMD_ACK, 16'd513, 10'd0);

        // Zero timeout behaves as one tick for segments sent from now on: the
        // new segment expires on every tick, older timers keep counting down.
        settle();
        write_reg(REG_TIMEOUT, 32'd0);
        send_item(CMD_OFFER, 16'd0, 10'd50);
        send_item(CMD_TICK, 16'd0, 10'd0);
        send_item(CMD_TICK, 16'd0, 10'd0);

        // Random phases with idling on both sides. Modulus above range, start
        // at the top of the field.
        calm <= 1'b0;
        run_phase(32'd131071, 32'd3, 32'd65535, 8);
        // Modulus below range, shortest timeout.
        run_phase(32'd0, 32'd1, 32'd1, 8);
        // Small modulus with the start beyond it.
        run_phase(32'd100, 32'd5, 32'd250, 8);

        // Long receiver hold-off while offers keep coming: the window fills,
        // results back up and item ready stays low.
        run_phase(32'd65536, 32'd65535, 32'd0, 0);
        hold_req <= 1'b1;
        repeat (10) send_item(CMD_OFFER, SEQ_W'($urandom_range(0, 65535)),
                              LEN_W'($urandom_range(1, 1023)));
        repeat (4) random_item();

        // A stretch with no idling at all.
        calm <= 1'b1;
        run_phase(32'd25601, 32'd2, 32'd12345, 8);
        calm <= 1'b0;
        run_phase(32'd2, 32'd4, 32'd0, 8);

        // End of data: a few segments, the end marker, an offer after it and a
        // repeated marker, then ACK everything so the window reports done.
        run_phase(32'd65536, 32'd7, 32'd40000, 0);
        send_item(CMD_OFFER, 16'd0, 10'd40);
        send_item(CMD_OFFER, 16'd0, 10'd60);
        send_item(CMD_OFFER, 16'd0, 10'd0);
        send_item(CMD_OFFER, 16'd0, 10'd77);
        send_item(CMD_OFFER, 16'd0, 10'd0);
        send_item(CMD_TICK, 16'd0, 10'd0);
        settle();
        drain_window();
        send_item(CMD_OFFER, 16'd0, 10'd5);
        send_item(CMD_TICK, 16'd0, 10'd0);

        // Wait out the last beats, then give stray beats time to show up.
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
